[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the colour fader RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/lcf_pkg.sv]
// ----------------------------------------------------------------------------
// lcf_pkg
// Widths, command and frame codes, register indexes and constants of the
// LED colour fader.
// ----------------------------------------------------------------------------
package lcf_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int SECS_W   = 8;
    localparam int TIME_W   = 32;
    localparam int KIND_W   = 2;
    localparam int LEVEL_W  = 8;
    localparam int COLOUR_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // Request commands
    localparam logic [CMD_W-1:0] CMD_TIMECODE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SYSTIME  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MESSAGE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POLL     = 2'd3;

    // Result frame kinds
    localparam logic [KIND_W-1:0] KIND_TIMECODE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SYSTIME  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MESSAGE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MASTER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLON   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE = 3'd4;

    // Blink modes
    localparam logic [1:0] BLINK_OFF  = 2'd0;
    localparam logic [1:0] BLINK_DOWN = 2'd1;

    // Levels, fade lengths and reset values
    localparam logic [LEVEL_W-1:0]  FULL_LEVEL    = 8'd255;
    localparam logic [11:0]         BLINK_MS      = 12'd1000;
    localparam logic [11:0]         MESSAGE_MS    = 12'd3000;
    localparam logic [SECS_W-1:0]   SECONDS_RESET = 8'd60;
    localparam logic [COLOUR_W-1:0] DIGIT_RESET   = 24'hFF0000;
    localparam logic [COLOUR_W-1:0] COLON_RESET   = 24'hFFFF00;
    localparam logic [COLOUR_W-1:0] MESSAGE_RESET = 24'hFFFFFF;

    // Reciprocals floor(2^RECIP_SHIFT / divisor) for the constant divider
    localparam int          RECIP_SHIFT = 20;
    localparam logic [12:0] RECIP_255   = 13'd4112;
    localparam logic [12:0] RECIP_1000  = 13'd1048;
    localparam logic [12:0] RECIP_3000  = 13'd349;

endpackage

[design/lcf_if.sv]
// ----------------------------------------------------------------------------
// lcf_if
// Valid/ready channels of the LED colour fader: request, result and
// configuration write.
// ----------------------------------------------------------------------------
interface lcf_req_if import lcf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [SECS_W-1:0]   seconds_units;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, output cmd, output seconds_units, output now_ms,
                    input ready);
    modport sink   (input valid, input cmd, input seconds_units, input now_ms,
                    output ready);
endinterface

interface lcf_res_if import lcf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  frame_kind;
    logic [LEVEL_W-1:0] main_red;
    logic [LEVEL_W-1:0] main_green;
    logic [LEVEL_W-1:0] main_blue;
    logic [LEVEL_W-1:0] colon_red;
    logic [LEVEL_W-1:0] colon_green;
    logic [LEVEL_W-1:0] colon_blue;

    modport source (output valid, output frame_kind, output main_red, output main_green,
                    output main_blue, output colon_red, output colon_green,
                    output colon_blue, input ready);
    modport sink   (input valid, input frame_kind, input main_red, input main_green,
                    input main_blue, input colon_red, input colon_green,
                    input colon_blue, output ready);
endinterface

interface lcf_cfg_if import lcf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/led_colour_fader_with_colon_blink.sv]
// ----------------------------------------------------------------------------
// led_colour_fader_with_colon_blink
// RGB drive levels for a clock display: master brightness, colon blink fade
// and message fade-in, computed by one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   i_req  takes one request word (cmd, seconds_units, now_ms); o_res gives
//   exactly one result word per request. i_cfg writes a register by index at
//   any edge where its valid is high (ready is always high); write only while
//   the block is idle.
//   Every level is a product divided by 255, 1000 or 3000. Each such step
//   uses the one shared multiplier in turn: product, reciprocal multiply,
//   then a remainder check that corrects the quotient by one. Result valid
//   rises in the same cycle as i_req.ready, and no request is taken while
//   the previous one is still being computed.
//   The result sits in an output register, so a new request is taken while
//   the previous word waits; a further finished word waits until o_res is
//   taken, and i_req.ready stays low meanwhile.
//   Reset (synchronous, active low) restores the register defaults, clears
//   any running message and sets the last seconds digit to 60.
// ----------------------------------------------------------------------------
module led_colour_fader_with_colon_blink import lcf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lcf_req_if.sink      i_req,
    lcf_res_if.source    o_res,
    lcf_cfg_if.sink      i_cfg
);

`include "assert_macros.svh"

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_RECIP, S_FIX, S_EMIT} t_state;

    typedef enum logic [3:0] {
        OP_MAIN0, OP_MAIN1, OP_MAIN2,
        OP_COLON0, OP_COLON1, OP_COLON2,
        OP_RAMP, OP_LEVEL,
        OP_FADE0, OP_FADE1, OP_FADE2
    } t_op;

    typedef enum logic [1:0] {DIV_255, DIV_1000, DIV_3000} t_div;

    function automatic logic [LEVEL_W-1:0] chan_of(input logic [COLOUR_W-1:0] c,
                                                   input logic [1:0] idx);
        logic [LEVEL_W-1:0] v;
        case (idx)
            2'd0:    v = c[23:16];
            2'd1:    v = c[15:8];
            default: v = c[7:0];
        endcase
        return v;
    endfunction

    // Control and configuration
    t_state               r_state;
    t_op                  r_op;
    logic                 r_out_valid;
    logic [LEVEL_W-1:0]   r_master;
    logic [1:0]           r_blink_mode;
    logic [COLOUR_W-1:0]  r_digit;
    logic [COLOUR_W-1:0]  r_colon_col;
    logic [COLOUR_W-1:0]  r_msg_col;
    logic [SECS_W-1:0]    r_last_secs;
    logic [TIME_W-1:0]    r_blink_start;
    logic                 r_msg_active;
    logic [TIME_W-1:0]    r_msg_start;

    // Per-item flags and working values
    logic                 r_msg;
    logic                 r_black;
    logic                 r_fade;
    logic [11:0]          r_e;
    logic [LEVEL_W-1:0]   r_level;
    logic [19:0]          r_prod;
    logic [LEVEL_W-1:0]   r_q0;
    logic [KIND_W-1:0]    r_kind;
    logic [LEVEL_W-1:0]   r_main  [3];
    logic [LEVEL_W-1:0]   r_colon [3];

    // Output register
    logic [KIND_W-1:0]    r_out_kind;
    logic [LEVEL_W-1:0]   r_out_main  [3];
    logic [LEVEL_W-1:0]   r_out_colon [3];

    logic [LEVEL_W-1:0]   m_eff;
    logic [TIME_W-1:0]    msg_e;
    logic [TIME_W-1:0]    blink_e;
    logic                 msg_done;
    logic                 fade_on;
    logic [1:0]           ch;
    logic [11:0]          op_a;
    logic [LEVEL_W-1:0]   op_b;
    t_div                 op_div;
    logic [11:0]          div_val;
    logic [12:0]          div_recip;
    logic [19:0]          mul_x;
    logic [12:0]          mul_y;
    logic [27:0]          mul_p;
    logic [19:0]          rem;
    logic [LEVEL_W-1:0]   q_fix;
    logic                 accept;
    logic                 emit_go;

    // A master of 0 acts as full level; full level times c over 255 is c
    assign m_eff = (r_master == '0) ? FULL_LEVEL : r_master;

    // Elapsed times of the running message and of the colon blink
    assign msg_e    = i_req.now_ms - r_msg_start;
    assign blink_e  = i_req.now_ms - r_blink_start;
    assign msg_done = (msg_e >= TIME_W'(MESSAGE_MS));
    assign fade_on  = (blink_e < TIME_W'(BLINK_MS));

    assign accept  = i_req.valid && (r_state == S_IDLE);
    assign emit_go = (r_state == S_EMIT) && (!r_out_valid || o_res.ready);

    // Pick the colour channel of the current step
    always_comb begin
        case (r_op)
            OP_MAIN0, OP_COLON0, OP_FADE0: ch = 2'd0;
            OP_MAIN1, OP_COLON1, OP_FADE1: ch = 2'd1;
            default:                       ch = 2'd2;
        endcase
    end

    // Select operands and divisor of the current step
    always_comb begin
        op_a   = {4'b0, m_eff};
        op_b   = chan_of(r_colon_col, ch);
        op_div = DIV_255;
        case (r_op)
            OP_MAIN0, OP_MAIN1, OP_MAIN2: begin
                if (r_msg) begin
                    op_a   = r_e;
                    op_b   = chan_of(r_msg_col, ch);
                    op_div = DIV_3000;
                end else begin
                    op_b   = chan_of(r_digit, ch);
                end
            end
            OP_RAMP: begin
                op_a   = r_e;
                op_b   = FULL_LEVEL;
                op_div = DIV_1000;
            end
            OP_LEVEL: begin
                op_b   = r_level;
            end
            OP_FADE0, OP_FADE1, OP_FADE2: begin
                op_a   = {4'b0, r_level};
            end
            default: begin
                op_a   = {4'b0, m_eff};
            end
        endcase
    end

    always_comb begin
        case (op_div)
            DIV_1000: begin
                div_val   = BLINK_MS;
                div_recip = RECIP_1000;
            end
            DIV_3000: begin
                div_val   = MESSAGE_MS;
                div_recip = RECIP_3000;
            end
            default: begin
                div_val   = {4'b0, FULL_LEVEL};
                div_recip = RECIP_255;
            end
        endcase
    end

    // Shared multiplier: product, reciprocal estimate, then quotient times divisor
    always_comb begin
        case (r_state)
            S_MUL: begin
                mul_x = {8'b0, op_a};
                mul_y = {5'b0, op_b};
            end
            S_RECIP: begin
                mul_x = r_prod;
                mul_y = div_recip;
            end
            S_FIX: begin
                mul_x = {12'b0, r_q0};
                mul_y = {1'b0, div_val};
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    // Every product of the sequence stays below 2^28
    assign mul_p = 28'(mul_x) * 28'(mul_y);

    // Correct the low estimate by one where the remainder reaches the divisor
    assign rem   = r_prod - mul_p[19:0];
    assign q_fix = (rem >= {8'b0, div_val}) ? (r_q0 + 8'd1) : r_q0;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_res.valid       = r_out_valid;
    assign o_res.frame_kind  = r_out_kind;
    assign o_res.main_red    = r_out_main[0];
    assign o_res.main_green  = r_out_main[1];
    assign o_res.main_blue   = r_out_main[2];
    assign o_res.colon_red   = r_out_colon[0];
    assign o_res.colon_green = r_out_colon[1];
    assign o_res.colon_blue  = r_out_colon[2];

    // Sequencer, state, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_op          <= OP_MAIN0;
            r_out_valid   <= 1'b0;
            r_master      <= FULL_LEVEL;
            r_blink_mode  <= BLINK_DOWN;
            r_digit       <= DIGIT_RESET;
            r_colon_col   <= COLON_RESET;
            r_msg_col     <= MESSAGE_RESET;
            r_last_secs   <= SECONDS_RESET;
            r_blink_start <= '0;
            r_msg_active  <= 1'b0;
            r_msg_start   <= '0;
        end else begin
            // Take configuration writes
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_MASTER:  r_master     <= i_cfg.data[7:0];
                    REG_BLINK:   r_blink_mode <= i_cfg.data[1:0];
                    REG_DIGIT:   r_digit      <= i_cfg.data;
                    REG_COLON:   r_colon_col  <= i_cfg.data;
                    REG_MESSAGE: r_msg_col    <= i_cfg.data;
                    default: ;
                endcase
            end

            // Drop the output word once taken, unless a new word replaces it
            if (r_out_valid && o_res.ready && !emit_go) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= OP_MAIN0;
                        r_msg   <= 1'b0;
                        r_black <= 1'b0;
                        r_fade  <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            r_main[i]  <= '0;
                            r_colon[i] <= '0;
                        end
                        if (i_req.cmd == CMD_MESSAGE || i_req.cmd == CMD_POLL) begin
                            // Start or end a message, no frame
                            if (i_req.cmd == CMD_MESSAGE) begin
                                r_msg_start  <= i_req.now_ms;
                                r_msg_active <= 1'b1;
                            end else if (r_msg_active && msg_done) begin
                                r_msg_active <= 1'b0;
                            end
                            r_kind  <= KIND_NONE;
                            r_state <= S_EMIT;
                        end else if (r_msg_active) begin
                            // Message fade replaces the frame
                            r_msg   <= 1'b1;
                            r_e     <= msg_done ? MESSAGE_MS : msg_e[11:0];
                            r_kind  <= KIND_MESSAGE;
                            r_state <= S_MUL;
                        end else begin
                            r_kind  <= i_req.cmd;
                            r_e     <= {2'b0, blink_e[9:0]};
                            if (i_req.cmd == CMD_TIMECODE && r_blink_mode != BLINK_OFF) begin
                                if (i_req.seconds_units != r_last_secs) begin
                                    r_last_secs   <= i_req.seconds_units;
                                    r_blink_start <= i_req.now_ms;
                                    r_black       <= 1'b1;
                                end else begin
                                    r_fade        <= fade_on;
                                end
                            end
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_p[19:0];
                    r_state <= S_RECIP;
                end
                S_RECIP: begin
                    r_q0    <= mul_p[RECIP_SHIFT +: LEVEL_W];
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    // Store the quotient of this step
                    case (r_op)
                        OP_MAIN0, OP_MAIN1, OP_MAIN2:    r_main[ch]  <= q_fix;
                        OP_COLON0, OP_COLON1, OP_COLON2: r_colon[ch] <= q_fix;
                        OP_RAMP: begin
                            r_level <= (r_blink_mode == BLINK_DOWN) ? (FULL_LEVEL - q_fix)
                                                                    : q_fix;
                        end
                        OP_LEVEL:                        r_level     <= q_fix;
                        default:                         r_colon[ch] <= q_fix;
                    endcase
                    // Advance to the next step or finish
                    if ((r_op == OP_MAIN2 && (r_msg || r_black)) ||
                        (r_op == OP_COLON2 && !r_fade) || r_op == OP_FADE2) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_op    <= t_op'(r_op + 4'd1);
                        r_state <= S_MUL;
                    end
                end
                S_EMIT: begin
                    // Hold until the output register is free
                    if (emit_go) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_kind;
                        for (int i = 0; i < 3; i++) begin
                            r_out_main[i]  <= r_main[i];
                            r_out_colon[i] <= r_colon[i];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // An accepted word keeps the request side busy in the next cycle
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !i_req.ready)
    // The reciprocal estimate is never more than one below the quotient
    `ASSERT_IMPL(a_rem_bound, i_clk, i_rst_n, r_state == S_FIX, rem < {7'b0, div_val, 1'b0})
    // Message steps stop after the main channels
    `ASSERT_IMPL(a_msg_ops, i_clk, i_rst_n, r_msg && r_state == S_MUL,
                 r_op == OP_MAIN0 || r_op == OP_MAIN1 || r_op == OP_MAIN2)
    // Message frames carry black colons
    `ASSERT_IMPL(a_msg_colon, i_clk, i_rst_n, r_out_valid && r_out_kind == KIND_MESSAGE,
                 r_out_colon[0] == '0 && r_out_colon[1] == '0 && r_out_colon[2] == '0)

endmodule
